// ===== sv/assert_macros.svh =====
// Assertion shorthands for the checker file.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define KLEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that post holds in the cycle after pre.
`define KLEC_ASSERT_NEXT(lbl, pre, post, msg) \
  `KLEC_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== sv/klec_pkg.sv =====
`timescale 1ns / 1ps

package klec_pkg;

  // Default geometry
  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int LINE_DEPTH_DEF  = 256;

  // Field widths
  localparam int FUNC_W     = 3;
  localparam int SCAN_W     = 8;
  localparam int TIDX_W     = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int LEN_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_KEY     = 3'd0,
    FN_ARM     = 3'd1,
    FN_DISARM  = 3'd2,
    FN_RD_CELL = 3'd3,
    FN_RD_LINE = 3'd4,
    FN_PLACE   = 3'd5
  } func_t;

  localparam logic [CHAR_W-1:0]  CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0]  CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
  localparam logic [COLOR_W-1:0] FG_TEXT  = 4'hF;
  localparam logic [COLOR_W-1:0] FG_BLANK = 4'h7;

  // Set-1 make code to ASCII; release and unmapped codes give zero.
  function automatic logic [CHAR_W-1:0] scan_to_ascii(input logic [SCAN_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      8'h01: ch = 8'h1B;
      8'h02: ch = 8'h31;
      8'h03: ch = 8'h32;
      8'h04: ch = 8'h33;
      8'h05: ch = 8'h34;
      8'h06: ch = 8'h35;
      8'h07: ch = 8'h36;
      8'h08: ch = 8'h37;
      8'h09: ch = 8'h38;
      8'h0A: ch = 8'h39;
      8'h0B: ch = 8'h30;
      8'h0C: ch = 8'h2D;
      8'h0D: ch = 8'h3D;
      8'h0E: ch = 8'h08;
      8'h0F: ch = 8'h09;
      8'h10: ch = 8'h71;
      8'h11: ch = 8'h77;
      8'h12: ch = 8'h65;
      8'h13: ch = 8'h72;
      8'h14: ch = 8'h74;
      8'h15: ch = 8'h79;
      8'h16: ch = 8'h75;
      8'h17: ch = 8'h69;
      8'h18: ch = 8'h6F;
      8'h19: ch = 8'h70;
      8'h1A: ch = 8'h5B;
      8'h1B: ch = 8'h5D;
      8'h1C: ch = 8'h0A;
      8'h1E: ch = 8'h61;
      8'h1F: ch = 8'h73;
      8'h20: ch = 8'h64;
      8'h21: ch = 8'h66;
      8'h22: ch = 8'h67;
      8'h23: ch = 8'h68;
      8'h24: ch = 8'h6A;
      8'h25: ch = 8'h6B;
      8'h26: ch = 8'h6C;
      8'h27: ch = 8'h3B;
      8'h28: ch = 8'h27;
      8'h29: ch = 8'h60;
      8'h2B: ch = 8'h5C;
      8'h2C: ch = 8'h7A;
      8'h2D: ch = 8'h78;
      8'h2E: ch = 8'h63;
      8'h2F: ch = 8'h76;
      8'h30: ch = 8'h62;
      8'h31: ch = 8'h6E;
      8'h32: ch = 8'h6D;
      8'h33: ch = 8'h2C;
      8'h34: ch = 8'h2E;
      8'h35: ch = 8'h2F;
      8'h37: ch = 8'h2A;
      8'h39: ch = 8'h20;
      8'h4A: ch = 8'h2D;
      8'h4E: ch = 8'h2B;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/keyboard_line_editor_text_console.sv =====
`timescale 1ns / 1ps
// Items: arm, disarm and unused codes go straight to the response; a cell or line read
//   waits on the memory; a cursor placement subtracts one row per cycle; a backspace
//   walks back over empty cells; an item that scrolls moves every cell up a row.
// Throughput: one item at a time; the screen memory's single read port sets the scroll length.
// Reset: synchronous, active low; a clearing pass then zeroes both memories while
//   in_tready stays low.
module keyboard_line_editor_text_console #(
  parameter int SCREEN_COLS = klec_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = klec_pkg::SCREEN_ROWS_DEF,
  parameter int LINE_DEPTH  = klec_pkg::LINE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] scancode, [18:8] target_index, [23:19] zero
  input  logic [klec_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] func
  input  logic [klec_pkg::FUNC_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [12] input_armed, [20:13] line_length,
  // [28:21] read_char, [32:29] read_color, [39:33] zero
  output logic [klec_pkg::OUT_DATA_W-1:0]  out_tdata,
  // line_done
  output logic                             out_tlast
);
  import klec_pkg::*;

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int LW    = $clog2(LINE_DEPTH);
  localparam int MAXD  = (CELLS > LINE_DEPTH) ? CELLS : LINE_DEPTH;
  localparam int CLRW  = $clog2(MAXD);
  localparam int PADW  = OUT_DATA_W - (ROW_W + COL_W + 1 + LEN_W + CHAR_W + COLOR_W);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RDWAIT,
    ST_PLACE,
    ST_BS_RD,
    ST_BS_CHK,
    ST_SCRL,
    ST_BLANK,
    ST_RESP
  } state_t;

  // Control and item state
  state_t                 state_r, state_nxt;
  logic [CLRW-1:0]        clr_r, clr_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [CW-1:0]          col_r, col_nxt;
  logic [LW-1:0]          lc_r, lc_nxt;
  logic                   armed_r, armed_nxt;
  logic                   done_r, done_nxt;
  logic [CHAR_W-1:0]      rch_r, rch_nxt;
  logic [COLOR_W-1:0]     rcol_r, rcol_nxt;
  logic                   rd_line_r, rd_line_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [AW-1:0]          pwa_r, pwa_nxt;
  logic                   pend_r, pend_nxt;
  logic                   more_r, more_nxt;
  logic [RW-1:0]          prow_r, prow_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  // Memory ports
  logic                   scr_we, scr_re;
  logic [AW-1:0]          scr_wa, scr_ra;
  logic [CELL_W-1:0]      scr_wd;
  logic [CELL_W-1:0]      scr_rd_r;
  logic                   lin_we, lin_re;
  logic [LW-1:0]          lin_wa, lin_ra;
  logic [CHAR_W-1:0]      lin_wd;
  logic [CHAR_W-1:0]      lin_rd_r;

  logic [CELL_W-1:0]      scr_mem [CELLS];
  logic [CHAR_W-1:0]      lin_mem [LINE_DEPTH];

  // Input field decode
  logic [SCAN_W-1:0]      scan;
  logic [TIDX_W-1:0]      tidx;
  func_t                  func;
  logic [CHAR_W-1:0]      ch;
  logic                   idx_in_scr, idx_in_lin;
  logic [AW-1:0]          cur_addr;
  logic [LW-1:0]          lc_inc;
  logic                   lc_full, col_last, row_last;

  assign scan       = in_tdata[SCAN_W-1:0];
  assign tidx       = in_tdata[SCAN_W+TIDX_W-1:SCAN_W];
  assign func       = func_t'(in_tuser);
  assign ch         = scan_to_ascii(scan);
  assign idx_in_scr = 32'(tidx) < CELLS;
  assign idx_in_lin = 32'(tidx) < LINE_DEPTH;
  // Linear cell address of the cursor
  assign cur_addr   = AW'(32'(row_r) * SCREEN_COLS + 32'(col_r));
  assign lc_inc     = lc_r + 1'b1;
  // One slot is held back: the line accepts at most LINE_DEPTH-1 characters
  assign lc_full    = 32'(lc_r) >= LINE_DEPTH - 1;
  assign col_last   = 32'(col_r) == SCREEN_COLS - 1;
  assign row_last   = 32'(row_r) == SCREEN_ROWS - 1;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    lc_nxt        = lc_r;
    armed_nxt     = armed_r;
    done_nxt      = done_r;
    rch_nxt       = rch_r;
    rcol_nxt      = rcol_r;
    rd_line_nxt   = rd_line_r;
    addr_nxt      = addr_r;
    pwa_nxt       = pwa_r;
    pend_nxt      = pend_r;
    more_nxt      = more_r;
    prow_nxt      = prow_r;
    // Drop the result once the sink takes it
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    scr_we = 1'b0;
    scr_wa = '0;
    scr_wd = '0;
    scr_re = 1'b0;
    scr_ra = '0;
    lin_we = 1'b0;
    lin_wa = '0;
    lin_wd = '0;
    lin_re = 1'b0;
    lin_ra = '0;

    case (state_r)
      // Sweep both memories to zero after reset
      ST_CLR: begin
        scr_we = 32'(clr_r) < CELLS;
        scr_wa = AW'(clr_r);
        lin_we = 32'(clr_r) < LINE_DEPTH;
        lin_wa = LW'(clr_r);
        if (32'(clr_r) == MAXD - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          done_nxt    = 1'b0;
          rch_nxt     = '0;
          rcol_nxt    = '0;
          rd_line_nxt = 1'b0;
          state_nxt   = ST_RESP;
          case (func)
            FN_KEY: begin
              if (!armed_r) begin
                lc_nxt = '0;
              end else if (ch == CH_NONE) begin
                // release or unmapped code: ignore
              end else if (ch == CH_BS) begin
                if (lc_r != '0) begin
                  lc_nxt    = lc_r - 1'b1;
                  lin_we    = 1'b1;
                  lin_wa    = lc_r - 1'b1;
                  addr_nxt  = cur_addr;
                  state_nxt = ST_BS_RD;
                end
              end else if (ch == CH_LF) begin
                col_nxt   = '0;
                lc_nxt    = '0;
                armed_nxt = 1'b0;
                done_nxt  = 1'b1;
                if (row_last) begin
                  addr_nxt  = AW'(SCREEN_COLS);
                  more_nxt  = 1'b1;
                  pend_nxt  = 1'b0;
                  state_nxt = ST_SCRL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else if (!lc_full) begin
                lin_we = 1'b1;
                lin_wa = lc_r;
                lin_wd = ch;
                scr_we = 1'b1;
                scr_wa = cur_addr;
                scr_wd = {FG_TEXT, ch};
                lc_nxt = lc_inc;
                // The character that fills the line leaves the cursor on its cell
                if (32'(lc_inc) < LINE_DEPTH - 1) begin
                  if (!col_last) begin
                    col_nxt = col_r + 1'b1;
                  end else if (!row_last) begin
                    row_nxt = row_r + 1'b1;
                    col_nxt = '0;
                  end else begin
                    col_nxt   = '0;
                    addr_nxt  = AW'(SCREEN_COLS);
                    more_nxt  = 1'b1;
                    pend_nxt  = 1'b0;
                    state_nxt = ST_SCRL;
                  end
                end
              end
            end
            FN_ARM: begin
              armed_nxt = 1'b1;
            end
            FN_DISARM: begin
              armed_nxt = 1'b0;
              lc_nxt    = '0;
            end
            FN_RD_CELL: begin
              if (idx_in_scr) begin
                scr_re    = 1'b1;
                scr_ra    = AW'(tidx);
                state_nxt = ST_RDWAIT;
              end
            end
            FN_RD_LINE: begin
              if (idx_in_lin) begin
                lin_re      = 1'b1;
                lin_ra      = LW'(tidx);
                rd_line_nxt = 1'b1;
                state_nxt   = ST_RDWAIT;
              end
            end
            FN_PLACE: begin
              if (idx_in_scr) begin
                addr_nxt  = AW'(tidx);
                prow_nxt  = '0;
                state_nxt = ST_PLACE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        if (rd_line_r) begin
          rch_nxt  = lin_rd_r;
          rcol_nxt = '0;
        end else begin
          rch_nxt  = scr_rd_r[CHAR_W-1:0];
          rcol_nxt = scr_rd_r[CELL_W-1:CHAR_W];
        end
        state_nxt = ST_RESP;
      end

      // Split the index into row and column, one row per cycle
      ST_PLACE: begin
        if (32'(addr_r) >= SCREEN_COLS) begin
          addr_nxt = addr_r - AW'(SCREEN_COLS);
          prow_nxt = prow_r + 1'b1;
        end else begin
          row_nxt   = prow_r;
          col_nxt   = CW'(addr_r);
          state_nxt = ST_RESP;
        end
      end

      ST_BS_RD: begin
        scr_re    = 1'b1;
        scr_ra    = addr_r;
        state_nxt = ST_BS_CHK;
      end

      // Step back over empty cells, then blank the cell the walk stops on
      ST_BS_CHK: begin
        if (scr_rd_r[CHAR_W-1:0] == CH_NONE && addr_r != '0) begin
          addr_nxt = addr_r - 1'b1;
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
          end else begin
            row_nxt = row_r - 1'b1;
            col_nxt = CW'(SCREEN_COLS - 1);
          end
          state_nxt = ST_BS_RD;
        end else begin
          scr_we    = 1'b1;
          scr_wa    = addr_r;
          scr_wd    = {FG_BLANK, CH_NONE};
          state_nxt = ST_RESP;
        end
      end

      // Read cell n, write it to n-SCREEN_COLS in the next cycle
      ST_SCRL: begin
        if (pend_r) begin
          scr_we = 1'b1;
          scr_wa = pwa_r;
          scr_wd = {FG_TEXT, scr_rd_r[CHAR_W-1:0]};
        end
        if (more_r) begin
          scr_re   = 1'b1;
          scr_ra   = addr_r;
          pwa_nxt  = addr_r - AW'(SCREEN_COLS);
          pend_nxt = 1'b1;
          if (addr_r == AW'(CELLS - 1)) begin
            more_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end else begin
          pend_nxt  = 1'b0;
          addr_nxt  = AW'(CELLS - SCREEN_COLS);
          state_nxt = ST_BLANK;
        end
      end

      ST_BLANK: begin
        scr_we = 1'b1;
        scr_wa = addr_r;
        scr_wd = {FG_BLANK, CH_NONE};
        if (addr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // Hold until the output register is free, then load the result
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = done_r;
          out_data_nxt  = {{PADW{1'b0}}, rcol_r, rch_r, LEN_W'(lc_r), armed_r,
                           COL_W'(col_r), ROW_W'(row_r)};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      lc_r        <= '0;
      armed_r     <= 1'b0;
      done_r      <= 1'b0;
      rch_r       <= '0;
      rcol_r      <= '0;
      rd_line_r   <= 1'b0;
      addr_r      <= '0;
      pwa_r       <= '0;
      pend_r      <= 1'b0;
      more_r      <= 1'b0;
      prow_r      <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      lc_r        <= lc_nxt;
      armed_r     <= armed_nxt;
      done_r      <= done_nxt;
      rch_r       <= rch_nxt;
      rcol_r      <= rcol_nxt;
      rd_line_r   <= rd_line_nxt;
      addr_r      <= addr_nxt;
      pwa_r       <= pwa_nxt;
      pend_r      <= pend_nxt;
      more_r      <= more_nxt;
      prow_r      <= prow_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Screen store: character in the low byte, foreground above it
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_wa] <= scr_wd;
    end
    if (scr_re) begin
      scr_rd_r <= scr_mem[scr_ra];
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (lin_we) begin
      lin_mem[lin_wa] <= lin_wd;
    end
    if (lin_re) begin
      lin_rd_r <= lin_mem[lin_ra];
    end
  end

endmodule

// ===== sv/klec_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module klec_checker #(
  parameter int SCREEN_COLS = klec_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = klec_pkg::SCREEN_ROWS_DEF,
  parameter int LINE_DEPTH  = klec_pkg::LINE_DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [klec_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import klec_pkg::*;

  logic             in_xfer;
  logic [LEN_W-1:0] len;

  assign in_xfer = in_tvalid && in_tready;
  assign len     = out_tdata[20:13];

  // A stalled result holds its value
  `KLEC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // Items are taken one at a time
  `KLEC_ASSERT_NEXT(a_one_item, in_xfer, !in_tready, "input ready right after a transfer")

  // Cursor stays on the screen
  `KLEC_ASSERT(a_cursor_range, out_tvalid |-> (32'(out_tdata[4:0]) < SCREEN_ROWS) &&
    (32'(out_tdata[11:5]) < SCREEN_COLS), "cursor off screen")

  // Enter leaves the console disarmed with an empty line at column zero
  `KLEC_ASSERT(a_enter_clears, out_tvalid && out_tlast |-> !out_tdata[12] &&
    len == '0 && out_tdata[11:5] == '0, "enter did not reset the line")

  // A disarmed console never holds characters
  `KLEC_ASSERT(a_disarmed_empty, out_tvalid && !out_tdata[12] |-> len == '0,
    "line not empty while disarmed")

endmodule

bind keyboard_line_editor_text_console klec_checker #(
  .SCREEN_COLS(SCREEN_COLS),
  .SCREEN_ROWS(SCREEN_ROWS),
  .LINE_DEPTH(LINE_DEPTH)
) u_klec_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the line-input text console.
// A queue of commands is built up front: a short directed opening, then
// random typing sessions, cursor moves, read-backs and noise. A clocked
// driver offers the commands in bursts, and a clocked monitor takes the
// results while stalling on its own pattern. Every accepted input transfer
// runs through a local model of the console; its result is queued and
// compared field by field with the next result transfer.
module tb_top;
  import klec_pkg::*;

  // Geometry of the instance (package defaults).
  localparam int COLS       = SCREEN_COLS_DEF;
  localparam int ROWS       = SCREEN_ROWS_DEF;
  localparam int LINE_SLOTS = LINE_DEPTH_DEF;
  localparam int CELLS      = COLS * ROWS;
  localparam int LINE_CAP   = LINE_SLOTS - 1;
  localparam int IDX_TOP    = 2047;

  // Function codes that the package leaves unnamed; the block ignores them.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  // Scancodes used by name.
  localparam logic [SCAN_W-1:0] SC_A         = 8'h1E;
  localparam logic [SCAN_W-1:0] SC_Q         = 8'h10;
  localparam logic [SCAN_W-1:0] SC_W         = 8'h11;
  localparam logic [SCAN_W-1:0] SC_BACKSPACE = 8'h0E;
  localparam logic [SCAN_W-1:0] SC_ENTER     = 8'h1C;
  localparam logic [SCAN_W-1:0] SC_BREAK     = 8'h80;
  localparam logic [SCAN_W-1:0] SC_UNMAPPED  = 8'hFF;

  // Set-1 make codes 0x00..0x4F to ASCII, code 0x00 in the top byte.
  localparam logic [80*8-1:0] KEYMAP = {
    128'h001B_3132_3334_3536_3738_3930_2D3D_0809,
    128'h7177_6572_7479_7569_6F70_5B5D_0A00_6173,
    128'h6466_6768_6A6B_6C3B_2760_005C_7A78_6376,
    128'h626E_6D2C_2E2F_002A_0020_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_2D00_0000_2B00
  };

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SCAN_W-1:0] code;
    logic [TIDX_W-1:0] idx;
    logic              drain;  // hold this one back until every result is in
  } console_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               armed;
    logic [LEN_W-1:0]   len;
    logic               done;
    logic [CHAR_W-1:0]  rch;
    logic [COLOR_W-1:0] rcol;
  } console_view_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;  // [7:0] scancode, [18:8] target_index, [23:19] zero
  logic [FUNC_W-1:0]     in_tuser  = '0;  // [2:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [4:0] cursor_row, [11:5] cursor_col, [12] input_armed, [20:13] line_length,
  // [28:21] read_char, [32:29] read_color, [39:33] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;   // line_done

  keyboard_line_editor_text_console dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Console model state.
  logic [CELL_W-1:0] screen   [CELLS];
  logic [CHAR_W-1:0] line_buf [LINE_SLOTS];
  int                line_len;
  bit                armed;
  int                cur_row;
  int                cur_col;

  console_cmd_t  pending_cmds [$];
  console_view_t console_views [$];

  int cmds_queued;
  int items_taken;
  int results_seen;
  int mismatch_count;
  bit hold_off = 1'b0;
  int burst_left = 1;
  int gap_left;
  int rx_mode;
  logic [6:0] rx_phase = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset once; the block then runs its clearing pass.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ------------------------------------------------------------------
  // Model of the console
  // ------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] key_char(input logic [SCAN_W-1:0] code);
    int k;
    k = code;
    if (k < 80) return KEYMAP[(79 - k) * 8 +: 8];
    return CH_NONE;
  endfunction

  // Move every row up one, repaint kept text bright, blank the bottom row.
  function automatic void scroll_screen();
    for (int r = 1; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen[(r - 1) * COLS + c] = {FG_TEXT, screen[r * COLS + c][CHAR_W-1:0]};
    for (int c = 0; c < COLS; c++)
      screen[(ROWS - 1) * COLS + c] = {FG_BLANK, CH_NONE};
  endfunction

  // Apply one scancode; return 1 when it was an enter that ended the line.
  function automatic bit press_key(input logic [SCAN_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    int r;
    int c;
    bit stop;
    ch = key_char(code);
    r = cur_row;
    c = cur_col;
    if (!armed) begin
      line_len = 0;
      return 1'b0;
    end
    if (ch == CH_NONE) return 1'b0;
    // Full line: only backspace and enter still act.
    if (line_len >= LINE_CAP && ch != CH_LF && ch != CH_BS) return 1'b0;
    if (ch == CH_BS) begin
      if (line_len != 0) begin
        line_len--;
        line_buf[line_len] = CH_NONE;
        // Walk back over empty cells, never past the top-left corner.
        stop = 1'b0;
        while (!stop && screen[(r * COLS + c) % CELLS][CHAR_W-1:0] == CH_NONE) begin
          if (c > 0) begin
            c--;
          end else if (r > 0) begin
            r--;
            c = COLS - 1;
          end else begin
            stop = 1'b1;
          end
        end
        screen[r * COLS + c] = {FG_BLANK, CH_NONE};
        cur_row = r;
        cur_col = c;
      end
      return 1'b0;
    end
    if (ch == CH_LF) begin
      if (r < ROWS - 1) cur_row = r + 1;
      else scroll_screen();
      cur_col = 0;
      line_len = 0;
      armed = 1'b0;
      return 1'b1;
    end
    line_buf[line_len] = ch;
    screen[r * COLS + c] = {FG_TEXT, ch};
    line_len++;
    // The character that fills the line leaves the cursor where it is.
    if (line_len < LINE_CAP) begin
      if (c < COLS - 1) begin
        cur_col = c + 1;
      end else if (r < ROWS - 1) begin
        cur_row = r + 1;
        cur_col = 0;
      end else begin
        scroll_screen();
        cur_col = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic console_view_t console_apply(input logic [FUNC_W-1:0] fn,
                                                  input logic [SCAN_W-1:0] code,
                                                  input logic [TIDX_W-1:0] idx);
    console_view_t v;
    v = '0;
    case (fn)
      FN_KEY:     v.done = press_key(code);
      FN_ARM:     armed = 1'b1;
      FN_DISARM: begin
        line_len = 0;
        armed = 1'b0;
      end
      FN_RD_CELL: begin
        if (idx < CELLS) begin
          v.rch  = screen[idx][CHAR_W-1:0];
          v.rcol = screen[idx][CELL_W-1:CHAR_W];
        end
      end
      FN_RD_LINE: if (idx < LINE_SLOTS) v.rch = line_buf[idx];
      FN_PLACE: begin
        if (idx < CELLS) begin
          cur_row = idx / COLS;
          cur_col = idx % COLS;
        end
      end
      default: ;
    endcase
    v.row   = ROW_W'(cur_row);
    v.col   = COL_W'(cur_col);
    v.armed = armed;
    v.len   = LEN_W'(line_len);
    return v;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  task automatic queue_cmd(input logic [FUNC_W-1:0] fn, input logic [SCAN_W-1:0] code,
                           input logic [TIDX_W-1:0] idx, input bit drain);
    console_cmd_t cmd;
    cmd.func  = fn;
    cmd.code  = code;
    cmd.idx   = idx;
    cmd.drain = drain;
    pending_cmds.push_back(cmd);
    cmds_queued++;
  endtask

  // Scancode command; the index field is random filler.
  task automatic queue_key(input logic [SCAN_W-1:0] code);
    queue_cmd(FN_KEY, code, TIDX_W'($urandom_range(0, IDX_TOP)), 1'b0);
  endtask

  // Non-key command; the scancode field is random filler.
  task automatic queue_op(input logic [FUNC_W-1:0] fn, input int idx);
    queue_cmd(fn, SCAN_W'($urandom_range(0, 255)), TIDX_W'(idx), 1'b0);
  endtask

  // Pick a make code that lands a character in the line.
  function automatic logic [SCAN_W-1:0] pick_text_code();
    logic [SCAN_W-1:0] code;
    code = SCAN_W'($urandom_range(1, 79));
    while (key_char(code) == CH_NONE || key_char(code) == CH_BS || key_char(code) == CH_LF)
      code = SCAN_W'($urandom_range(1, 79));
    return code;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  initial begin
    int len;
    int p;
    bit filled;

    // Model starts from the cleared state.
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    for (int i = 0; i < LINE_SLOTS; i++) line_buf[i] = '0;
    line_len = 0;
    armed    = 1'b0;
    cur_row  = 0;
    cur_col  = 0;

    // Directed opening.
    queue_op(FN_RD_CELL, 0);              // cleared screen reads zero
    queue_op(FN_RD_LINE, LINE_SLOTS - 1);
    queue_key(SC_A);                      // key while disarmed
    queue_op(FN_PLACE, CELLS - 1);        // bottom-right corner
    queue_op(FN_ARM, 0);
    queue_key(SC_BACKSPACE);              // backspace on an empty line
    queue_key(SC_A);                      // last cell, so the screen scrolls
    queue_op(FN_RD_CELL, CELLS - COLS - 1);
    queue_op(FN_RD_CELL, CELLS - COLS);   // fresh bottom row is blank
    queue_key(SC_A | SC_BREAK);           // release code, ignored
    queue_key(SC_UNMAPPED);
    queue_key(SC_BACKSPACE);              // walks back one row
    queue_key(SC_ENTER);                  // next row, disarms
    queue_op(FN_ARM, 0);
    queue_key(SC_ENTER);                  // enter on the last row scrolls
    queue_op(FN_PLACE, IDX_TOP);          // beyond the screen: cursor stays
    queue_op(FN_RD_CELL, CELLS);
    queue_op(FN_RD_LINE, LINE_SLOTS);
    queue_op(FN_SPARE_LO, 0);
    queue_op(FN_SPARE_HI, IDX_TOP);
    queue_op(FN_PLACE, 0);
    queue_key(SC_Q);
    queue_key(SC_W);
    queue_op(FN_PLACE, 0);
    queue_key(SC_BACKSPACE);
    queue_key(SC_BACKSPACE);              // still disarmed, so this backspace does nothing
    queue_op(FN_DISARM, 0);

    // Random part: mostly typing sessions with random content.
    filled = 1'b0;
    while (cmds_queued < 290) begin
      p = $urandom_range(0, 99);
      if (!filled && cmds_queued >= 30) begin
        // Fill the line to the cap, starting low on the screen so it scrolls,
        // then offer one key past the cap.
        filled = 1'b1;
        queue_op(FN_PLACE, (ROWS - 3) * COLS + $urandom_range(0, COLS - 1));
        queue_cmd(FN_ARM, SCAN_W'($urandom_range(0, 255)),
                  TIDX_W'($urandom_range(0, IDX_TOP)), 1'b1);
        for (int k = 0; k < LINE_CAP + 1; k++) queue_key(pick_text_code());
        queue_op(FN_RD_LINE, LINE_CAP - 1);
        queue_op(FN_RD_LINE, LINE_CAP);
        queue_key(SC_BACKSPACE);
        queue_op(FN_RD_CELL, $urandom_range(0, CELLS - 1));
        queue_key(SC_ENTER);
      end else if (p < 55) begin
        queue_cmd(FN_ARM, SCAN_W'($urandom_range(0, 255)),
                  TIDX_W'($urandom_range(0, IDX_TOP)), $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0)
          queue_op(FN_PLACE, (ROWS - 1) * COLS + $urandom_range(0, COLS - 1));
        len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          p = $urandom_range(0, 19);
          if (p < 14) queue_key(pick_text_code());
          else if (p < 17) queue_key(SC_BACKSPACE);
          else if (p < 18) queue_key(pick_text_code() | SC_BREAK);
          else if (p < 19) queue_op(FN_RD_LINE, $urandom_range(0, 31));
          else queue_op(FN_RD_CELL, $urandom_range(0, IDX_TOP));
        end
        p = $urandom_range(0, 9);
        if (p < 7) queue_key(SC_ENTER);
        else if (p < 8) queue_op(FN_DISARM, $urandom_range(0, IDX_TOP));
      end else if (p < 70) begin
        if ($urandom_range(0, 3) == 0)
          queue_op(FN_PLACE, (ROWS - 1) * COLS + $urandom_range(0, COLS - 1));
        else
          queue_op(FN_PLACE, $urandom_range(0, IDX_TOP));
      end else if (p < 85) begin
        queue_op(FN_RD_CELL, $urandom_range(0, IDX_TOP));
        if ($urandom_range(0, 2) == 0) queue_op(FN_RD_LINE, $urandom_range(0, 31));
        else queue_op(FN_RD_LINE, $urandom_range(0, IDX_TOP));
      end else begin
        // Noise: any function code, any field values.
        queue_cmd(FUNC_W'($urandom_range(0, 7)), SCAN_W'($urandom_range(0, 255)),
                  TIDX_W'($urandom_range(0, IDX_TOP)), 1'b0);
      end
    end

    // Wait for every command to go out, then for every result to come back.
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (console_views.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ------------------------------------------------------------------
  // Driver: offer commands in bursts with random gaps
  // ------------------------------------------------------------------

  always @(posedge clk) begin : drive
    console_cmd_t  head;
    console_view_t view;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // A transfer at this edge: predict its result now.
      if (in_tvalid && in_tready) begin
        view = console_apply(in_tuser, in_tdata[SCAN_W-1:0], in_tdata[SCAN_W +: TIDX_W]);
        console_views.push_back(view);
        items_taken++;
      end
      if (pending_cmds.size() != 0) head = pending_cmds[0];
      if (in_tvalid && !in_tready) begin
        // Hold the offered command until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0 && !(head.drain && console_views.size() != 0)) begin
        head = pending_cmds.pop_front();
        in_tuser  <= head.func;
        in_tdata  <= {5'd0, head.idx, head.code};
        in_tvalid <= 1'b1;
        // Advance the burst; at its end pick a gap, often none at all.
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: take results on a stall pattern and check them
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    console_view_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (console_views.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[31:0], 0);
        end else begin
          want = console_views.pop_front();
          if (out_tdata[4:0] != want.row)
            report_mismatch("cursor_row", out_tdata[4:0], want.row);
          if (out_tdata[11:5] != want.col)
            report_mismatch("cursor_col", out_tdata[11:5], want.col);
          if (out_tdata[12] != want.armed)
            report_mismatch("input_armed", out_tdata[12], want.armed);
          if (out_tdata[20:13] != want.len)
            report_mismatch("line_length", out_tdata[20:13], want.len);
          if (out_tlast != want.done)
            report_mismatch("line_done", out_tlast, want.done);
          if (out_tdata[28:21] != want.rch)
            report_mismatch("read_char", out_tdata[28:21], want.rch);
          if (out_tdata[32:29] != want.rcol)
            report_mismatch("read_color", out_tdata[32:29], want.rcol);
        end
        results_seen++;
      end
      // Change stall mode each time rx_phase wraps: always ready, coin flip, or one in four.
      rx_phase <= rx_phase + 1'b1;
      if (rx_phase == '0) rx_mode <= $urandom_range(0, 2);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (rx_phase[1:0] == 2'd0);
        endcase
      end
    end
  end

  // Long receiver hold-off once traffic is flowing, so the block backs up
  // and stalls its input while the driver keeps offering.
  initial begin
    while (items_taken < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

endmodule
